// ===== sv/b58_pkg.sv =====
// ----------------------------------------------------------------------------
// b58_pkg
// Shared types and constants for the base58 encoder: the queued request
// between front and back, the radix-58 reciprocal and the alphabet lookup.
// ----------------------------------------------------------------------------
package b58_pkg;

    // digit and count widths fixed by the field ranges
    localparam int DIGIT_W = 6;
    localparam int CNT_W   = 6;
    localparam logic [CNT_W-1:0] CNT_MAX = 6'd63;

    // depth of the queue between front and back
    localparam int Q_DEPTH = 2;

    // divide by 58: q = (x * RECIP_58) >> RECIP_SHIFT, exact for x < 16384
    localparam int FOLD_W      = 14;
    localparam int RECIP_W     = 15;
    localparam logic [RECIP_W-1:0] RECIP_58 = 15'd18079;
    localparam int RECIP_SHIFT = 20;
    localparam int PROD_W      = FOLD_W + RECIP_W;
    localparam int QUOT_W      = PROD_W - RECIP_SHIFT;

    // output characters
    localparam logic [6:0] CHAR_ONE  = 7'h31;
    localparam logic [6:0] CHAR_NONE = 7'h00;

    // one classified byte request handed from front to back
    typedef struct packed {
        logic [7:0]       data;
        logic             fold;
        logic             last;
        logic             err;
        logic [CNT_W-1:0] lz;
    } t_cmd;

    // base58 alphabet, digits without 0 O I l
    function automatic logic [6:0] b58_char(input logic [DIGIT_W-1:0] d);
        logic [6:0] dd;
        dd = {1'b0, d};
        if (d < 6'd9) begin
            return 7'h31 + dd;
        end else if (d < 6'd17) begin
            return 7'h41 + (dd - 7'd9);
        end else if (d < 6'd22) begin
            return 7'h4A + (dd - 7'd17);
        end else if (d < 6'd33) begin
            return 7'h50 + (dd - 7'd22);
        end else if (d < 6'd44) begin
            return 7'h61 + (dd - 7'd33);
        end else if (d < 6'd58) begin
            return 7'h6D + (dd - 7'd44);
        end else begin
            return 7'h7A;
        end
    endfunction

endpackage

// ===== sv/base58_encoder.sv =====
// ----------------------------------------------------------------------------
// base58_encoder
// Base58 (bitcoin alphabet) encoder: bytes in, one character per request out.
//
//   channel  | direction | handshake          | payload
//   ---------+-----------+--------------------+----------------------------------
//   input    | in        | i_valid / o_stall  | i_data_byte, i_last_byte
//   output   | out       | o_valid / i_stall  | o_out_char, o_last_char, o_too_long
//
// The back end pops each request; a significant byte is then folded into the
// store digit by digit through the RAM, top digit first; other bytes need only the pop.
// At message end it scans the store for the first significant digit, emits a
// '1' per leading zero byte and each digit character (or the error character),
// and clears the store; an output stall holds the sequence until it is taken.
// Input stalls only while the two-entry queue is full; reset leaves the store empty.
// ----------------------------------------------------------------------------
module base58_encoder import b58_pkg::*; #(
    parameter int MAX_LEN = 32,
    parameter int DIGITS  = 45
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char,
    output logic       o_too_long
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic q_pop;

    // front: classify incoming bytes
    b58_front #(
        .MAX_LEN (MAX_LEN)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_push      (push),
        .o_cmd       (push_cmd),
        .i_full      (q_full)
    );

    // request queue
    b58_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_cmd   (q_cmd),
        .i_pop   (q_pop)
    );

    // back: fold and emit
    b58_back #(
        .DIGITS (DIGITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (q_cmd),
        .o_q_pop     (q_pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .o_too_long  (o_too_long)
    );

    // error result is a lone, final, empty character
    a_err_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_too_long) |-> (o_last_char && (o_out_char == CHAR_NONE)))
        else $error("error result malformed");

    // regular results always lie in the alphabet's character range
    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_too_long) |-> ((o_out_char >= 7'h31) && (o_out_char <= 7'h7A)))
        else $error("character outside alphabet");

    // back end only takes requests that are queued
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> q_valid)
        else $error("pop from empty queue");

    // a full queue stalls the input the same cycle
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> (!push || q_full == 1'b0 || $past(q_pop) == 1'b0 && !push))
        else $error("push into full queue");

endmodule

// ===== sv/b58_ram.sv =====
// ----------------------------------------------------------------------------
// b58_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module b58_ram #(
    parameter int WIDTH = 6,
    parameter int DEPTH = 45
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // registered read port, holds when not enabled
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== sv/b58_front.sv =====
// ----------------------------------------------------------------------------
// b58_front
// Accepts message bytes, tracks length, overflow and leading zeros, and
// classifies each byte into a request for the back end.
// ----------------------------------------------------------------------------
module b58_front import b58_pkg::*; #(
    parameter int MAX_LEN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_full
);

    logic [CNT_W-1:0] r_bcnt, n_bcnt;
    logic [CNT_W-1:0] r_lz, n_lz;
    logic             r_inlz, n_inlz;
    logic             r_ovf, n_ovf;
    logic             zero_lead;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    // classify the byte against the message state
    always_comb begin
        n_bcnt    = (r_bcnt < CNT_MAX) ? r_bcnt + 1'b1 : r_bcnt;
        n_ovf     = r_ovf || ({1'b0, n_bcnt} > 7'(MAX_LEN));
        zero_lead = r_inlz && (i_data_byte == 8'd0);
        n_lz      = r_lz;
        n_inlz    = r_inlz;
        if (!n_ovf) begin
            if (zero_lead) begin
                n_lz = (r_lz < CNT_MAX) ? r_lz + 1'b1 : r_lz;
            end else begin
                n_inlz = 1'b0;
            end
        end
        o_cmd.data = i_data_byte;
        o_cmd.fold = !n_ovf && !zero_lead;
        o_cmd.last = i_last_byte;
        o_cmd.err  = n_ovf;
        o_cmd.lz   = n_lz;
    end

    // message state, back to start after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bcnt <= '0;
            r_lz   <= '0;
            r_inlz <= 1'b1;
            r_ovf  <= 1'b0;
        end else if (o_push) begin
            if (i_last_byte) begin
                r_bcnt <= '0;
                r_lz   <= '0;
                r_inlz <= 1'b1;
                r_ovf  <= 1'b0;
            end else begin
                r_bcnt <= n_bcnt;
                r_lz   <= n_lz;
                r_inlz <= n_inlz;
                r_ovf  <= n_ovf;
            end
        end
    end

endmodule

// ===== sv/b58_queue.sv =====
// ----------------------------------------------------------------------------
// b58_queue
// Short request queue between front and back.
// ----------------------------------------------------------------------------
module b58_queue import b58_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_valid,
    output t_cmd o_cmd,
    input  logic i_pop
);

    localparam int PW = $clog2(Q_DEPTH);

    t_cmd          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wp;
    logic [PW-1:0] r_rp;
    logic [PW:0]   r_cnt;

    assign o_full  = (r_cnt == (PW+1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rp];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= (r_wp == PW'(Q_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(Q_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

endmodule

// ===== sv/b58_back.sv =====
// ----------------------------------------------------------------------------
// b58_back
// Folds bytes into the base-58 digit store one digit per cycle, then emits
// leading '1's and the significant digits through an output register.
// ----------------------------------------------------------------------------
module b58_back import b58_pkg::*; #(
    parameter int DIGITS = 45
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_q_cmd,
    output logic       o_q_pop,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char,
    output logic       o_too_long
);

    localparam int IW = $clog2(DIGITS);
    localparam logic [IW-1:0] TOP_IDX = IW'(DIGITS - 1);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_FOLD = 4'd1;
    localparam logic [3:0] S_SRD  = 4'd2;
    localparam logic [3:0] S_SCHK = 4'd3;
    localparam logic [3:0] S_ZERO = 4'd4;
    localparam logic [3:0] S_ERD  = 4'd5;
    localparam logic [3:0] S_ECHK = 4'd6;
    localparam logic [3:0] S_ERR  = 4'd7;
    localparam logic [3:0] S_DONE = 4'd8;

    logic [3:0]         r_state, n_state;
    logic [IW-1:0]      r_idx, n_idx;
    logic [7:0]         r_carry, n_carry;
    logic               r_last, n_last;
    logic [CNT_W-1:0]   r_lz, n_lz;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_has, n_has;
    logic [DIGITS-1:0]  r_dvld, n_dvld;
    logic               r_rd_vld;

    logic               r_ovalid, n_ovalid;
    logic [6:0]         r_char, n_char;
    logic               r_lastc, n_lastc;
    logic               r_err, n_err;

    logic               rd_en;
    logic [IW-1:0]      rd_addr;
    logic               wr_en;
    logic [DIGIT_W-1:0] rd_data;
    logic [DIGIT_W-1:0] dig;
    logic [FOLD_W-1:0]  fold_x;
    logic [PROD_W-1:0]  prod;
    logic [QUOT_W-1:0]  quot;
    logic [FOLD_W:0]    qm58;
    logic [FOLD_W-1:0]  rem_x;
    logic [DIGIT_W-1:0] rem;
    logic               out_free;
    logic               emit_last;

    b58_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (DIGITS)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_idx),
        .i_wr_data (rem),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // never-written digits read as zero
    assign dig = r_rd_vld ? rd_data : '0;

    // one digit step: x = 256*d + carry, split by 58
    always_comb begin
        fold_x = {dig, r_carry};
        prod   = PROD_W'(fold_x) * PROD_W'(RECIP_58);
        quot   = prod[PROD_W-1:RECIP_SHIFT];
        qm58   = (FOLD_W+1)'({quot, 6'b0}) - (FOLD_W+1)'({quot, 2'b0})
               - (FOLD_W+1)'({quot, 1'b0});
        rem_x  = fold_x - qm58[FOLD_W-1:0];
        rem    = rem_x[DIGIT_W-1:0];
    end

    assign out_free = !r_ovalid || !i_stall;

    // sequencer
    always_comb begin
        n_state   = r_state;
        n_idx     = r_idx;
        n_carry   = r_carry;
        n_last    = r_last;
        n_lz      = r_lz;
        n_n       = r_n;
        n_has     = r_has;
        n_dvld    = r_dvld;
        n_ovalid  = r_ovalid && i_stall;
        n_char    = r_char;
        n_lastc   = r_lastc;
        n_err     = r_err;
        rd_en     = 1'b0;
        rd_addr   = r_idx;
        wr_en     = 1'b0;
        o_q_pop   = 1'b0;
        emit_last = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_carry = i_q_cmd.data;
                    n_last  = i_q_cmd.last;
                    n_lz    = i_q_cmd.lz;
                    n_n     = '0;
                    n_idx   = '0;
                    if (i_q_cmd.err) begin
                        n_state = i_q_cmd.last ? S_ERR : S_IDLE;
                    end else if (i_q_cmd.fold) begin
                        rd_en   = 1'b1;
                        rd_addr = TOP_IDX;
                        n_idx   = TOP_IDX;
                        n_state = S_FOLD;
                    end else begin
                        n_state = i_q_cmd.last ? S_SRD : S_IDLE;
                    end
                end
            end
            S_FOLD: begin
                wr_en         = 1'b1;
                n_dvld[r_idx] = 1'b1;
                n_carry       = quot[7:0];
                if (r_idx == '0) begin
                    n_state = r_last ? S_SRD : S_IDLE;
                end else begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx - 1'b1;
                    n_idx   = r_idx - 1'b1;
                end
            end
            // find the first significant digit
            S_SRD: begin
                rd_en   = 1'b1;
                n_state = S_SCHK;
            end
            S_SCHK: begin
                if (dig != '0) begin
                    n_has   = 1'b1;
                    n_state = S_ZERO;
                end else if (r_idx == TOP_IDX) begin
                    n_has   = 1'b0;
                    n_state = S_ZERO;
                end else begin
                    n_idx   = r_idx + 1'b1;
                    n_state = S_SRD;
                end
            end
            // one '1' per leading zero byte
            S_ZERO: begin
                if (r_lz == '0) begin
                    n_state = r_has ? S_ERD : S_DONE;
                end else if (out_free) begin
                    emit_last = ((r_lz == CNT_W'(1)) && !r_has) || (r_n == CNT_MAX);
                    n_ovalid  = 1'b1;
                    n_char    = CHAR_ONE;
                    n_lastc   = emit_last;
                    n_err     = 1'b0;
                    n_lz      = r_lz - 1'b1;
                    n_n       = r_n + 1'b1;
                    if (emit_last) begin
                        n_state = S_DONE;
                    end
                end
            end
            S_ERD: begin
                rd_en   = 1'b1;
                n_state = S_ECHK;
            end
            S_ECHK: begin
                if (out_free) begin
                    emit_last = (r_idx == TOP_IDX) || (r_n == CNT_MAX);
                    n_ovalid  = 1'b1;
                    n_char    = b58_char(dig);
                    n_lastc   = emit_last;
                    n_err     = 1'b0;
                    n_n       = r_n + 1'b1;
                    if (emit_last) begin
                        n_state = S_DONE;
                    end else begin
                        n_idx   = r_idx + 1'b1;
                        n_state = S_ERD;
                    end
                end
            end
            S_ERR: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    n_char   = CHAR_NONE;
                    n_lastc  = 1'b1;
                    n_err    = 1'b1;
                    n_state  = S_DONE;
                end
            end
            // empty the store for the next message
            S_DONE: begin
                n_dvld  = '0;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_dvld   <= '0;
            r_ovalid <= 1'b0;
            r_rd_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_dvld   <= n_dvld;
            r_ovalid <= n_ovalid;
            if (rd_en) begin
                r_rd_vld <= r_dvld[rd_addr];
            end
        end
    end

    // working and output payload registers
    always_ff @(posedge i_clk) begin
        r_idx   <= n_idx;
        r_carry <= n_carry;
        r_last  <= n_last;
        r_lz    <= n_lz;
        r_n     <= n_n;
        r_has   <= n_has;
        r_char  <= n_char;
        r_lastc <= n_lastc;
        r_err   <= n_err;
    end

    assign o_valid     = r_ovalid;
    assign o_out_char  = r_char;
    assign o_last_char = r_lastc;
    assign o_too_long  = r_err;

endmodule

// ===== test/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for base58_encoder. Byte requests go in with random gaps
// and output stalls. Each accepted byte updates a local copy of the encoder
// state, and each message end queues the characters that it should produce.
// Every accepted character is checked against the oldest queued one.
// ----------------------------------------------------------------------------
module testbench;

    localparam int MAX_LEN      = 32;
    localparam int DIGITS       = 45;
    localparam int CHAR_CAP     = 64;
    localparam int STALL_LIMIT  = 20000;
    localparam int DRAIN_CYCLES = 200;
    localparam int REPORT_MAX   = 10;

    // alphabet, digit value 0 is the leftmost character
    localparam logic [8*58-1:0] GLYPHS =
        "123456789ABCDEFGHJKLMNPQRSTUVWXYZabcdefghijkmnopqrstuvwxyz";

    typedef struct packed {
        logic [6:0] ch;
        logic       fin;
        logic       err;
    } t_char;

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_valid     = 1'b0;
    logic [7:0] i_data_byte = 8'h00;
    logic       i_last_byte = 1'b0;
    logic       i_stall     = 1'b0;
    logic       o_stall;
    logic       o_valid;
    logic [6:0] o_out_char;
    logic       o_last_char;
    logic       o_too_long;

    // local copy of the encoder state
    logic [5:0] digit_store [DIGITS];
    logic [5:0] zero_bytes;
    logic       zero_run;
    logic [5:0] msg_bytes;
    logic       msg_over;

    t_char pending_chars [$];
    t_char got_char;
    int    error_count = 0;
    int    items_sent  = 0;
    int    quiet_cycles = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;

    base58_encoder #(
        .MAX_LEN (MAX_LEN),
        .DIGITS  (DIGITS)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char),
        .o_too_long  (o_too_long)
    );

    always #10 i_clk = ~i_clk;

    function automatic logic [6:0] glyph(input int d);
        if (d > 57) begin
            d = 57;
        end
        return GLYPHS[8*(57-d) +: 7];
    endfunction

    function void clear_message();
        for (int k = 0; k < DIGITS; k++) begin
            digit_store[k] = '0;
        end
        zero_bytes = '0;
        zero_run   = 1'b1;
        msg_bytes  = '0;
        msg_over   = 1'b0;
    endfunction

    // fold one byte into the digit store and queue the characters at message end
    function void encode_byte(input logic [7:0] b, input logic fin);
        int unsigned carry;
        int          first;
        int          total;
        int          n;
        t_char       r;
        if (msg_bytes < 6'd63) begin
            msg_bytes = msg_bytes + 6'd1;
        end
        if (msg_bytes > MAX_LEN) begin
            msg_over = 1'b1;
        end
        if (!msg_over) begin
            if (zero_run && b == 8'h00) begin
                if (zero_bytes < 6'd63) begin
                    zero_bytes = zero_bytes + 6'd1;
                end
            end else begin
                zero_run = 1'b0;
                carry = 32'(b);
                for (int k = DIGITS - 1; k >= 0; k--) begin
                    carry = carry + 256 * digit_store[k];
                    digit_store[k] = 6'(carry % 58);
                    carry = carry / 58;
                end
            end
        end
        if (fin) begin
            if (msg_over) begin
                r.ch  = 7'h00;
                r.fin = 1'b1;
                r.err = 1'b1;
                pending_chars.push_back(r);
            end else begin
                first = 0;
                while (first < DIGITS && digit_store[first] == 6'd0) begin
                    first++;
                end
                total = zero_bytes + (DIGITS - first);
                if (total > CHAR_CAP) begin
                    total = CHAR_CAP;
                end
                for (n = 0; n < total; n++) begin
                    if (n < zero_bytes) begin
                        r.ch = glyph(0);
                    end else begin
                        r.ch = glyph(digit_store[first + n - zero_bytes]);
                    end
                    r.fin = (n == total - 1);
                    r.err = 1'b0;
                    pending_chars.push_back(r);
                end
            end
            clear_message();
        end
    endfunction

    // one byte request, with a random gap ahead of it
    task automatic send_byte(input logic [7:0] b, input logic fin);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= fin;
        @(posedge i_clk);
        while (o_stall) begin
            @(posedge i_clk);
        end
        encode_byte(b, fin);
        items_sent++;
    endtask

    function automatic logic [7:0] random_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    function automatic int random_length();
        int r;
        r = $urandom_range(99);
        if (r < 60) begin
            return $urandom_range(6, 1);
        end else if (r < 85) begin
            return $urandom_range(20, 7);
        end else if (r < 95) begin
            return $urandom_range(MAX_LEN, 21);
        end else begin
            return $urandom_range(MAX_LEN + 8, MAX_LEN + 1);
        end
    endfunction

    // message with random content, sometimes led by zeros or all zero
    task automatic send_random_message(input int len);
        int   lead;
        logic zero_msg;
        lead = ($urandom_range(3) == 0) ? $urandom_range(len) : 0;
        zero_msg = ($urandom_range(15) == 0);
        for (int k = 0; k < len; k++) begin
            send_byte((zero_msg || k < lead) ? 8'h00 : random_byte(), k == len - 1);
        end
    endtask

    // one-byte messages at the field extremes and the alphabet ends
    task automatic test_single_bytes();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_byte(8'h00, 1'b1);
        send_byte(8'h01, 1'b1);
        send_byte(8'h39, 1'b1);
        send_byte(8'h3A, 1'b1);
        send_byte(8'h80, 1'b1);
        send_byte(8'hFF, 1'b1);
    endtask

    // all-zero message, leading zeros, zeros after the first significant byte
    task automatic test_zero_runs();
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'h00, 1'b0);
        send_byte(8'h7F, 1'b1);
    endtask

    // longest encoding, most leading zeros, too long, and count saturation
    task automatic test_length_limits();
        send_idle_pct  = 38;
        recv_stall_pct = 38;
        for (int k = 0; k < MAX_LEN; k++) begin
            send_byte(8'hFF, k == MAX_LEN - 1);
        end
        for (int k = 0; k < MAX_LEN; k++) begin
            send_byte(8'h00, k == MAX_LEN - 1);
        end
        for (int k = 0; k <= MAX_LEN; k++) begin
            send_byte(random_byte(), k == MAX_LEN);
        end
        for (int k = 0; k < 66; k++) begin
            send_byte(random_byte(), k == 65);
        end
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input int quota);
        int stop_at;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        stop_at = items_sent + quota;
        while (items_sent < stop_at) begin
            send_random_message(random_length());
        end
    endtask

    // output stall pattern
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // check each accepted character against the oldest expected one
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (pending_chars.size() == 0) begin
                error_count++;
                if (error_count <= REPORT_MAX) begin
                    $display("unexpected char: got char %h last %b err %b",
                             o_out_char, o_last_char, o_too_long);
                end
            end else begin
                got_char = pending_chars.pop_front();
                if (o_out_char !== got_char.ch || o_last_char !== got_char.fin ||
                    o_too_long !== got_char.err) begin
                    error_count++;
                    if (error_count <= REPORT_MAX) begin
                        $display("mismatch: expected %h last %b err %b, got %h last %b err %b",
                                 got_char.ch, got_char.fin, got_char.err,
                                 o_out_char, o_last_char, o_too_long);
                    end
                end
            end
        end
    end

    // watchdog on cycles with no accepted byte or character
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        clear_message();
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_single_bytes();
        test_zero_runs();
        test_length_limits();
        test_random_traffic(0, 0, 30);
        test_random_traffic(81, 0, 30);
        test_random_traffic(0, 81, 30);
        test_random_traffic(38, 38, 30);

        // drain
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pending_chars.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && pending_chars.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

// ===== base58_encoder.f =====
sv/b58_pkg.sv
sv/b58_ram.sv
sv/b58_front.sv
sv/b58_queue.sv
sv/b58_back.sv
sv/base58_encoder.sv
test/testbench.sv
